### hdl/premultiplied_alpha_blit_blend_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the premultiplied alpha blit blender
// Clocked property checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PREMULTIPLIED_ALPHA_BLIT_BLEND_ASSERT_SVH
`define PREMULTIPLIED_ALPHA_BLIT_BLEND_ASSERT_SVH

`ifndef SYNTH

// Property checked at every rising clock edge outside reset.
`define PBB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define PBB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PBB_ASSERT(lbl, clk, rst, prop, msg)
`define PBB_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hdl/pbb_pkg.sv
// ----------------------------------------------------------------------------
// Premultiplied alpha blit blender package
// Shared widths, register codes, payload types, and the divide-by-255 and saturation helpers.
// ----------------------------------------------------------------------------
package pbb_pkg;

   // Pixel layout: four 8-bit channels, R in the low byte, A in the high byte.
   localparam int NumChan  = 4;
   localparam int ChanW    = 8;
   localparam int PixelW   = NumChan * ChanW;
   localparam int ProdW    = 2 * ChanW;
   localparam int AlphaIdx = NumChan - 1;

   localparam logic [ChanW-1:0] ChanMax  = 8'hFF;
   localparam logic [ChanW-1:0] ModReset = 8'hFF;

   // Depth of the queue between the front and the back.
   localparam int QDepth = 2;
   localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW  = $clog2(QDepth + 1);

   // Register file addressing.
   localparam int CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MOD_RED    = 3'd0,
      CSR_MOD_GREEN  = 3'd1,
      CSR_MOD_BLUE   = 3'd2,
      CSR_MOD_ALPHA  = 3'd3,
      CSR_SRC_FORMAT = 3'd4
   } csr_index_type;

   // Source pixel formats.
   typedef enum logic {
      FMT_RGBA = 1'b0,
      FMT_GRAY = 1'b1
   } src_format_type;

   typedef logic [NumChan-1:0][ChanW-1:0] pixel_type;

   // One classified item: source already expanded to four channels.
   typedef struct packed {
      pixel_type src;
      pixel_type dst;
   } pbb_item_type;

   // Modulation color handed from the register file to the datapath.
   typedef struct packed {
      pixel_type modulation;
   } pbb_cfg_type;

   // Rounded product / 255 for a product of two channels (at most 255*255).
   // Uses t = p + 128, q = (t + (t >> 8)) >> 8, which is exact over that range.
   function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] p);
      logic [ProdW:0] t;
      logic [ProdW:0] u;
      t = {1'b0, p} + (ProdW+1)'(128);
      u = t + (t >> ChanW);
      return u[ProdW-1:ChanW];
   endfunction

   // Clamp a nine-bit sum to one channel.
   function automatic logic [ChanW-1:0] sat8(input logic [ChanW:0] v);
      return v[ChanW] ? ChanMax : v[ChanW-1:0];
   endfunction

endpackage

### hdl/pbb_if.sv
// ----------------------------------------------------------------------------
// Premultiplied alpha blit blender channel interfaces
// Valid/ready channels for pixel requests, blended responses and register writes.
// ----------------------------------------------------------------------------

// Request channel: one source and one destination pixel per transfer.
interface pbb_req_if
   import pbb_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [PixelW-1:0] src_pixel;
   logic [PixelW-1:0] dst_pixel;

   modport source (output valid, output src_pixel, output dst_pixel, input ready);
   modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

// Response channel: one blended pixel per transfer.
interface pbb_rsp_if
   import pbb_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [PixelW-1:0] out_pixel;

   modport source (output valid, output out_pixel, input ready);
   modport sink   (input valid, input out_pixel, output ready);
endinterface

// Register write channel.
interface pbb_csr_if
   import pbb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   logic [ChanW-1:0]   wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

### hdl/pbb_front.sv
// ----------------------------------------------------------------------------
// Blender front end
// Holds the configuration registers, accepts request transfers, expands a
// grayscale source to four channels and registers the classified item.
// ----------------------------------------------------------------------------
module pbb_front
   import pbb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pbb_req_if.sink      req_bus,
   pbb_csr_if.sink      csr_bus,
   output pbb_cfg_type  cfg,
   output logic         item_valid,
   input  logic         item_ready,
   output pbb_item_type item
);

   pixel_type      mod_ff;
   pixel_type      mod_in;
   src_format_type fmt_ff;
   src_format_type fmt_in;
   logic           valid_ff;
   logic           valid_in;
   pbb_item_type   item_ff;
   pbb_item_type   item_in;
   logic           req_fire;

   // Register writes are always taken.
   assign csr_bus.ready = 1'b1;

   // Register write decode; indexes past the list are dropped.
   always_comb begin
      mod_in = mod_ff;
      fmt_in = fmt_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MOD_RED:    mod_in[0] = csr_bus.wdata;
            CSR_MOD_GREEN:  mod_in[1] = csr_bus.wdata;
            CSR_MOD_BLUE:   mod_in[2] = csr_bus.wdata;
            CSR_MOD_ALPHA:  mod_in[AlphaIdx] = csr_bus.wdata;
            CSR_SRC_FORMAT: fmt_in = src_format_type'(csr_bus.wdata[0]);
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= {NumChan{ModReset}};
         fmt_ff <= FMT_RGBA;
      end else begin
         mod_ff <= mod_in;
         fmt_ff <= fmt_in;
      end
   end

   assign cfg.modulation = mod_ff;

   // The holding register takes a new item when empty or when it drains.
   assign req_bus.ready = !valid_ff || item_ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Classify the source: a grayscale byte goes to all four channels.
   always_comb begin
      item_in.dst = pixel_type'(req_bus.dst_pixel);
      if (fmt_ff == FMT_GRAY) begin
         item_in.src = {NumChan{req_bus.src_pixel[ChanW-1:0]}};
      end else begin
         item_in.src = pixel_type'(req_bus.src_pixel);
      end
   end

   assign valid_in = req_bus.ready ? req_bus.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### hdl/pbb_queue.sv
// ----------------------------------------------------------------------------
// Blender item queue
// Short register queue that decouples the front end from the blend datapath.
// ----------------------------------------------------------------------------
module pbb_queue
   import pbb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  pbb_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output pbb_item_type pop_item
);

`include "premultiplied_alpha_blit_blend_assert.svh"

   pbb_item_type           entry_ff [QDepth];
   logic [QPtrW-1:0]       wr_ptr_ff;
   logic [QPtrW-1:0]       wr_ptr_in;
   logic [QPtrW-1:0]       rd_ptr_ff;
   logic [QPtrW-1:0]       rd_ptr_in;
   logic [QCntW-1:0]       count_ff;
   logic [QCntW-1:0]       count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != QCntW'(QDepth));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Occupancy stays within the queue depth.
   `PBB_ASSERT(a_count_bound, clock, reset, count_ff <= QCntW'(QDepth), "queue overfilled")
   // Occupancy rises by one after a push without a pop.
   `PBB_ASSERT(a_count_track, clock, reset, (push && !pop) |=> count_ff == $past(count_ff) + 1'b1, "queue count missed a push")

endmodule

### hdl/pbb_back.sv
// ----------------------------------------------------------------------------
// Blend datapath
// Four-stage pipeline: modulate products, divide by 255, destination
// products, then sum, saturate and hold in the output register.
// ----------------------------------------------------------------------------
module pbb_back
   import pbb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pbb_cfg_type  cfg,
   input  logic         item_valid,
   output logic         item_ready,
   input  pbb_item_type item,
   pbb_rsp_if.source    rsp_bus
);

`include "premultiplied_alpha_blit_blend_assert.svh"

   typedef logic [NumChan-1:0][ProdW-1:0] prod_vec_type;

   // Stage valids and stage enables.
   logic         v1_ff;
   logic         v2_ff;
   logic         v3_ff;
   logic         v4_ff;
   logic         rdy1;
   logic         rdy2;
   logic         rdy3;
   logic         rdy4;

   // Stage 1: source times modulation.
   prod_vec_type mprod_ff;
   prod_vec_type mprod_in;
   pixel_type    dst1_ff;
   // Stage 2: modulated source.
   pixel_type    src2_ff;
   pixel_type    src2_in;
   pixel_type    dst2_ff;
   // Stage 3: destination products; the alpha slot holds source times dst alpha.
   prod_vec_type dprod_ff;
   prod_vec_type dprod_in;
   pixel_type    src3_ff;
   logic [ChanW-1:0] dst_a3_ff;
   // Stage 4: blended pixel.
   pixel_type    out_ff;
   pixel_type    out_in;

   logic [ChanW-1:0] inv_alpha;
   logic [ChanW:0]   alpha_sum;

   // Backward ready chain: a stage loads when empty or when it drains.
   assign rdy4       = !v4_ff || rsp_bus.ready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign item_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= item_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Stage 1 logic: one 8x8 product per channel.
   always_comb begin
      for (int k = 0; k < NumChan; k++) begin
         mprod_in[k] = item.src[k] * cfg.modulation[k];
      end
   end

   // Stage 2 logic: rounded divide by 255.
   always_comb begin
      for (int k = 0; k < NumChan; k++) begin
         src2_in[k] = div255(mprod_ff[k]);
      end
   end

   // Stage 3 logic: destination color times inverse source alpha,
   // and source alpha times destination alpha.
   assign inv_alpha = ChanMax - src2_ff[AlphaIdx];

   always_comb begin
      for (int k = 0; k < AlphaIdx; k++) begin
         dprod_in[k] = dst2_ff[k] * inv_alpha;
      end
      dprod_in[AlphaIdx] = src2_ff[AlphaIdx] * dst2_ff[AlphaIdx];
   end

   // Stage 4 logic: color is src + dst*(1-sa); alpha is sa + da - sa*da.
   assign alpha_sum = {1'b0, src3_ff[AlphaIdx]} + {1'b0, dst_a3_ff}
                      - {1'b0, div255(dprod_ff[AlphaIdx])};

   always_comb begin
      for (int k = 0; k < AlphaIdx; k++) begin
         out_in[k] = sat8({1'b0, src3_ff[k]} + {1'b0, div255(dprod_ff[k])});
      end
      out_in[AlphaIdx] = sat8(alpha_sum);
   end

   // Payload registers load with their stage.
   always_ff @(posedge clock) begin
      if (rdy1 && item_valid) begin
         mprod_ff <= mprod_in;
         dst1_ff  <= item.dst;
      end
      if (rdy2 && v1_ff) begin
         src2_ff <= src2_in;
         dst2_ff <= dst1_ff;
      end
      if (rdy3 && v2_ff) begin
         dprod_ff  <= dprod_in;
         src3_ff   <= src2_ff;
         dst_a3_ff <= dst2_ff[AlphaIdx];
      end
      if (rdy4 && v3_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid     = v4_ff;
   assign rsp_bus.out_pixel = PixelW'(out_ff);

   // A finished item in the last compute stage reaches the output when it is free.
   `PBB_ASSERT(a_out_advance, clock, reset, (v3_ff && rdy4) |=> rsp_bus.valid, "blend result lost before output")
   // The datapath takes no item while its first stage is held full.
   `PBB_ASSERT(a_hold_stage1, clock, reset, (v1_ff && !rdy2) |-> !item_ready, "first stage overwritten while stalled")

endmodule

### hdl/premultiplied_alpha_blit_blend.sv
// ----------------------------------------------------------------------------
// Premultiplied alpha blit blender
// Blends a premultiplied source pixel over a destination RGBA8888 pixel with
// a programmable modulation color and an optional grayscale source.
// ----------------------------------------------------------------------------
//
//   Port     Direction  Carries
//   req_bus  in         src_pixel, dst_pixel
//   rsp_bus  out        out_pixel
//   csr_bus  in         index, wdata (register write)
//
// One pixel is accepted per clock while the response side keeps up.
// After its request transfer, a result passes the front register, a queue
// entry and the blend pipeline stages before it is presented on rsp_bus.
// The 8x8 multipliers sit in stages 1 and 3, and each stage holds one item.
// Reset is synchronous: it empties all stages and the queue and returns the
// modulation color to full scale and the source format to RGBA.
// A stalled response backs up the pipeline, then the two-entry queue, then
// the front register; register writes are taken every cycle.
//
module premultiplied_alpha_blit_blend
   import pbb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   pbb_req_if.sink   req_bus,
   pbb_rsp_if.source rsp_bus,
   pbb_csr_if.sink   csr_bus
);

   pbb_cfg_type  cfg;
   logic         front_valid;
   logic         front_ready;
   pbb_item_type front_item;
   logic         back_valid;
   logic         back_ready;
   pbb_item_type back_item;

   // Register file, intake and source classification.
   pbb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .cfg        (cfg),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   // Decoupling queue.
   pbb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   // Blend pipeline and output register.
   pbb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_bus    (rsp_bus)
   );

endmodule

### verif/premultiplied_alpha_blit_blend_test.sv
// ----------------------------------------------------------------------------
// Premultiplied alpha blit blender testbench
// Streams source/destination pixel pairs through the blender under several
// modulation colors and both source formats. Each accepted pair is blended
// by a local fixed-point predictor and compared with the returned pixel.
// ----------------------------------------------------------------------------
module premultiplied_alpha_blit_blend_test;
   import pbb_pkg::*;

   localparam int CycleLimit  = 100000;
   localparam int ReportLimit = 10;
   localparam int GapPercent  = 16;
   localparam int DrainCycles = 12;

   // One request: the source and destination words as they go on the bus.
   typedef struct packed {
      logic [PixelW-1:0] src;
      logic [PixelW-1:0] dst;
   } blit_pair_type;

   // One predicted blend, with its inputs kept for reporting.
   typedef struct packed {
      logic [PixelW-1:0] src;
      logic [PixelW-1:0] dst;
      pixel_type         out;
   } blend_result_type;

   typedef struct packed {
      logic [CsrIdxW-1:0] index;
      logic [ChanW-1:0]   wdata;
   } reg_write_type;

   logic clock;
   logic reset;

   pbb_req_if req_if ();
   pbb_rsp_if rsp_if ();
   pbb_csr_if csr_if ();

   premultiplied_alpha_blit_blend dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   blit_pair_type    pending_pairs[$];
   blend_result_type expected_blends[$];
   reg_write_type    csr_writes[$];

   // Register shadows that the predictor works from.
   pixel_type      mod_shadow;
   src_format_type fmt_shadow;

   bit no_gaps;
   int cycle_count;
   int mismatch_count;
   int checked_count;
   int accepted_count;
   int write_count;
   int setting_count;

   // Clock and the run's cycle limit.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles, %0d blends still outstanding",
                  cycle_count, expected_blends.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Random idle cycle for either side, unless the gap-free stretch is on.
   function automatic bit take_gap();
      return !no_gaps && ($urandom_range(99) < GapPercent);
   endfunction

   // Product of two channels divided by 255, rounded to nearest.
   function automatic int unsigned scale255(input int unsigned a, input int unsigned b);
      return (a * b + 127) / 255;
   endfunction

   // Premultiplied over blend of one pixel pair under the current registers.
   function automatic pixel_type blend_pixel(input logic [PixelW-1:0] src_word,
                                             input logic [PixelW-1:0] dst_word);
      pixel_type   res;
      int unsigned scaled[NumChan];
      int unsigned chan_in;
      int unsigned dst_chan;
      int unsigned inv;
      int unsigned sum;
      for (int k = 0; k < NumChan; k++) begin
         chan_in = (fmt_shadow == FMT_GRAY) ? src_word[ChanW-1:0] : src_word[ChanW*k +: ChanW];
         scaled[k] = scale255(chan_in, mod_shadow[k]);
      end
      inv = 255 - scaled[AlphaIdx];
      for (int k = 0; k < AlphaIdx; k++) begin
         sum = scaled[k] + scale255(dst_word[ChanW*k +: ChanW], inv);
         res[k] = (sum > 255) ? ChanMax : sum[ChanW-1:0];
      end
      dst_chan = dst_word[ChanW*AlphaIdx +: ChanW];
      sum = scaled[AlphaIdx] + dst_chan - scale255(scaled[AlphaIdx], dst_chan);
      res[AlphaIdx] = (sum > 255) ? ChanMax : sum[ChanW-1:0];
      return res;
   endfunction

   // Half well-formed premultiplied pixels, some extremes, the rest raw noise.
   function automatic logic [PixelW-1:0] random_pixel();
      pixel_type   px;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         px[AlphaIdx] = ChanW'($urandom_range(255));
         for (int k = 0; k < AlphaIdx; k++)
            px[k] = ChanW'($urandom_range(px[AlphaIdx]));
      end else if (pick < 65) begin
         for (int k = 0; k < NumChan; k++)
            px[k] = $urandom_range(1) ? ChanMax : '0;
      end else begin
         px = $urandom;
      end
      return px;
   endfunction

   // Request driver: one transfer per handshake, fed from the pending queue.
   always @(posedge clock) begin : req_drive
      blit_pair_type pair;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_blends.push_back('{req_if.src_pixel, req_if.dst_pixel,
                                        blend_pixel(req_if.src_pixel, req_if.dst_pixel)});
            accepted_count <= accepted_count + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_pairs.size() > 0 && !take_gap()) begin
               pair = pending_pairs.pop_front();
               req_if.valid     <= 1'b1;
               req_if.src_pixel <= pair.src;
               req_if.dst_pixel <= pair.dst;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each transfer against the oldest prediction.
   always @(posedge clock) begin : rsp_check
      blend_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_blends.size() == 0) begin
               if (mismatch_count < ReportLimit)
                  $display("Unexpected result %h with no blend outstanding",
                           rsp_if.out_pixel);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_blends.pop_front();
               checked_count <= checked_count + 1;
               if (rsp_if.out_pixel !== want.out) begin
                  if (mismatch_count < ReportLimit)
                     $display("Mismatch: src %h dst %h expected %h got %h",
                              want.src, want.dst, want.out, rsp_if.out_pixel);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         rsp_if.ready <= !take_gap();
      end
   end

   // Register write driver; shadows change on the transfer like the block's.
   always @(posedge clock) begin : csr_drive
      reg_write_type w;
      if (reset) begin
         csr_if.valid <= 1'b0;
         mod_shadow   <= {NumChan{ModReset}};
         fmt_shadow   <= FMT_RGBA;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_MOD_RED, CSR_MOD_GREEN, CSR_MOD_BLUE, CSR_MOD_ALPHA:
                  mod_shadow[csr_if.index[1:0]] <= csr_if.wdata;
               CSR_SRC_FORMAT:
                  fmt_shadow <= src_format_type'(csr_if.wdata[0]);
               default: ;
            endcase
            write_count <= write_count + 1;
         end
         if (!csr_if.valid || csr_if.ready) begin
            if (csr_writes.size() > 0) begin
               w = csr_writes.pop_front();
               csr_if.valid <= 1'b1;
               csr_if.index <= w.index;
               csr_if.wdata <= w.wdata;
            end else begin
               csr_if.valid <= 1'b0;
            end
         end
      end
   end

   task automatic queue_write(input logic [CsrIdxW-1:0] idx, input logic [ChanW-1:0] data);
      csr_writes.push_back('{idx, data});
   endtask

   task automatic queue_mods(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                             input logic [ChanW-1:0] b, input logic [ChanW-1:0] a);
      queue_write(CSR_MOD_RED, r);
      queue_write(CSR_MOD_GREEN, g);
      queue_write(CSR_MOD_BLUE, b);
      queue_write(CSR_MOD_ALPHA, a);
   endtask

   task automatic queue_pair(input logic [PixelW-1:0] src, input logic [PixelW-1:0] dst);
      pending_pairs.push_back('{src, dst});
   endtask

   task automatic queue_random_pairs(input int count);
      for (int i = 0; i < count; i++)
         queue_pair(random_pixel(), random_pixel());
   endtask

   // Block until every write and every blend has gone through.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (pending_pairs.size() != 0 || req_if.valid || expected_blends.size() != 0 ||
             csr_writes.size() != 0 || csr_if.valid);
   endtask

   // Stimulus: one phase per register setting, writes only while idle.
   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.src_pixel = '0;
      req_if.dst_pixel = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.wdata     = '0;
      no_gaps          = 1'b0;
      cycle_count      = 0;
      mismatch_count   = 0;
      checked_count    = 0;
      accepted_count   = 0;
      write_count      = 0;
      setting_count    = 1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset setting: full-scale modulation, RGBA source, directed corners.
      queue_pair(32'h0000_0000, 32'h0000_0000);
      queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
      queue_pair(32'hFF00_0000, 32'h1234_5678);
      queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
      // Colors above alpha: some of the color sums saturate.
      queue_pair(32'h00FF_FFFF, 32'hFFFF_FFFF);
      queue_pair(32'h00FF_FFFF, 32'h0000_0000);
      queue_pair(32'h80FF_00FF, 32'h7F00_FF00);
      queue_pair(32'h8080_8080, 32'h8080_8080);
      queue_pair(32'h0101_0101, 32'hFEFE_FEFE);
      queue_pair(32'h7F7F_7F7F, 32'h8181_8181);
      queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
      queue_pair(32'h4030_2010, 32'hC0B0_A090);
      queue_pair(32'hFE01_FE01, 32'h01FE_01FE);
      queue_random_pairs(200);
      wait_quiet();

      // Zero modulation: the source vanishes entirely.
      queue_mods(8'h00, 8'h00, 8'h00, 8'h00);
      wait_quiet();
      setting_count++;
      queue_random_pairs(100);
      wait_quiet();

      // Grayscale source with random upper write bits and random modulation.
      queue_mods(ChanW'($urandom), ChanW'($urandom), ChanW'($urandom), ChanW'($urandom));
      queue_write(CSR_SRC_FORMAT, (ChanW'($urandom) & 8'hFE) | ChanW'(FMT_GRAY));
      wait_quiet();
      setting_count++;
      // The upper source bits must not leak into the gray value.
      queue_pair(32'h1234_56FF, 32'h0000_0000);
      queue_pair(32'hFFFF_FF00, 32'hFFFF_FFFF);
      queue_pair(32'h0000_0080, 32'h8080_8080);
      queue_pair(32'hFFFF_FF7F, 32'h00FF_00FF);
      queue_random_pairs(250);
      wait_quiet();

      // Writes to unused indexes are dropped; the format bit keeps only bit 0.
      for (int idx = CSR_SRC_FORMAT + 1; idx < 2 ** CsrIdxW; idx++)
         queue_write(CsrIdxW'(idx), ChanW'($urandom));
      queue_mods(8'hFF, 8'h00, 8'h80, 8'h01);
      queue_write(CSR_SRC_FORMAT, 8'hFE);
      wait_quiet();
      setting_count++;
      no_gaps = 1'b1;
      queue_random_pairs(200);
      wait_quiet();
      no_gaps = 1'b0;

      // Random modulation, grayscale again.
      queue_mods(ChanW'($urandom), ChanW'($urandom), ChanW'($urandom), ChanW'($urandom));
      queue_write(CSR_SRC_FORMAT, ChanW'(FMT_GRAY));
      wait_quiet();
      setting_count++;
      queue_random_pairs(250);
      wait_quiet();

      // Full scale with grayscale source.
      queue_mods(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      wait_quiet();
      setting_count++;
      queue_random_pairs(100);
      wait_quiet();

      // Random modulation with alpha at an extreme, RGBA source.
      queue_mods(ChanW'($urandom), ChanW'($urandom), ChanW'($urandom), 8'h00);
      queue_write(CSR_SRC_FORMAT, ChanW'(FMT_RGBA));
      wait_quiet();
      setting_count++;
      queue_random_pairs(150);
      wait_quiet();

      // Let any stray response show up before the verdict.
      repeat (DrainCycles) @(negedge clock);

      $display("Blended %0d pixel pairs, %0d checked, across %0d register settings",
               accepted_count, checked_count, setting_count);
      $display("Register transfers: %0d, mismatches: %0d", write_count, mismatch_count);
      if (mismatch_count == 0 && expected_blends.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
